[rtl/rmth_pkg.sv]
// Shared constants and the per-chain command type for the running median block.
package rmth_pkg;

    // Default sizing of the block.
    localparam int CAPACITY_DEF     = 256;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Fixed width of the reported sample count.
    localparam int COUNT_W = 9;

    // Operation applied to one sorted chain.
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_PUSH    = 2'd1,
        OP_REPLACE = 2'd2
    } chain_op_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECIDE = 2'd1,
        ST_APPLY  = 2'd2,
        ST_REPORT = 2'd3
    } rmth_state_t;

endpackage

[rtl/rmth_cell.sv]
// One cell of a sorted chain: holds a single value and its valid bit.
module rmth_cell #(
    parameter int SW = rmth_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rmth_pkg::chain_op_t op,
    input  logic signed [SW-1:0] v,
    input  logic                is_head,
    input  logic                prev_lt,
    input  logic signed [SW-1:0] prev_val,
    input  logic                prev_valid,
    input  logic                next_lt,
    input  logic signed [SW-1:0] next_val,
    output logic signed [SW-1:0] val_out,
    output logic                valid_out,
    output logic                lt_out
);
    import rmth_pkg::*;

    logic signed [SW-1:0] val_reg;
    logic signed [SW-1:0] val_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 lt;

    // The broadcast value ranks before this cell's content, or the cell is empty.
    assign lt = !valid_reg || (v < val_reg);

    // Chain order is ascending from the head; a push shifts the tail outward,
    // a replace drops the head and slides the rest inward around the new value.
    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        unique case (op)
            OP_PUSH: begin
                if (lt) begin
                    val_next = prev_lt ? prev_val : v;
                end
                valid_next = valid_reg | prev_valid;
            end
            OP_REPLACE: begin
                if (next_lt) begin
                    val_next = (lt && !is_head) ? val_reg : v;
                end else begin
                    val_next = next_val;
                end
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    // Value register carries no reset; the valid bit does.
    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign val_out   = val_reg;
    assign valid_out = valid_reg;
    assign lt_out    = lt;

endmodule

[rtl/rmth_chain.sv]
// A row of cells forming one sorted chain with its smallest entry at the head.
module rmth_chain #(
    parameter int SW    = rmth_pkg::SAMPLE_WIDTH_DEF,
    parameter int DEPTH = (rmth_pkg::CAPACITY_DEF + 1) / 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rmth_pkg::chain_op_t  op,
    input  logic signed [SW-1:0] v,
    output logic signed [SW-1:0] head_val
);
    import rmth_pkg::*;

    logic signed [SW-1:0] cell_val   [DEPTH];
    logic                 cell_valid [DEPTH];
    logic                 cell_lt    [DEPTH];

    // Each cell sees its two neighbors; the ends see fixed boundary values.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 p_lt;
        logic signed [SW-1:0] p_val;
        logic                 p_valid;
        logic                 n_lt;
        logic signed [SW-1:0] n_val;

        if (i == 0) begin : g_head
            assign p_lt    = 1'b0;
            assign p_val   = '0;
            assign p_valid = 1'b1;
        end else begin : g_body
            assign p_lt    = cell_lt[i-1];
            assign p_val   = cell_val[i-1];
            assign p_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign n_lt  = 1'b1;
            assign n_val = '0;
        end else begin : g_inner
            assign n_lt  = cell_lt[i+1];
            assign n_val = cell_val[i+1];
        end

        rmth_cell #(
            .SW(SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (op),
            .v         (v),
            .is_head   ((i == 0) ? 1'b1 : 1'b0),
            .prev_lt   (p_lt),
            .prev_val  (p_val),
            .prev_valid(p_valid),
            .next_lt   (n_lt),
            .next_val  (n_val),
            .val_out   (cell_val[i]),
            .valid_out (cell_valid[i]),
            .lt_out    (cell_lt[i])
        );
    end

    assign head_val = cell_val[0];

endmodule

[rtl/running_median_two_heaps.sv]
// Top level of the running median block built from two sorted cell chains.
//
//   Channel | Ports                                           | Direction
//   --------+-------------------------------------------------+----------
//   input   | s_valid, s_ready, s_sample                      | in
//   result  | m_valid, m_ready, m_median_times_two,           | out
//           | m_sample_count, m_store_full                    |
//
// No new request is taken until the previous one has loaded its result. The
// accepting cycle captures the sample, the next chooses the chain operations
// from the two chain heads, the next updates every cell of both chains at
// once, and the last forms the median. The next request is accepted while
// the previous result still waits in the output register. A synchronous
// reset empties both chains at once. A stalled result holds the sequencer in
// its last state.
module running_median_two_heaps #(
    parameter int CAPACITY     = rmth_pkg::CAPACITY_DEF,
    parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]     s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_WIDTH:0]       m_median_times_two,
    output logic [rmth_pkg::COUNT_W-1:0]       m_sample_count,
    output logic                               m_store_full
);
    import rmth_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int HALF  = (CAPACITY + 1) / 2;
    localparam int HW    = $clog2(HALF + 1);
    localparam int TW    = HW + 1;

    rmth_state_t state_reg, state_next;

    logic signed [SW-1:0] sample_reg, sample_next;
    logic [HW-1:0]        lc_reg, lc_next;
    logic [HW-1:0]        uc_reg, uc_next;
    chain_op_t            lower_op_reg, lower_op_next;
    chain_op_t            upper_op_reg, upper_op_next;
    logic signed [SW-1:0] lower_v_reg, lower_v_next;
    logic signed [SW-1:0] upper_v_reg, upper_v_next;
    logic                 dropped_reg, dropped_next;

    logic                 m_valid_reg, m_valid_next;
    logic signed [SW:0]   median_reg, median_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 full_reg, full_next;

    logic signed [SW-1:0] lower_head;
    logic signed [SW-1:0] upper_head;
    logic signed [SW-1:0] ltop;
    logic signed [SW:0]   ltop_ext;
    logic signed [SW:0]   utop_ext;
    logic [TW-1:0]        total;

    // The lower half is kept inverted so that both chains sort ascending.
    rmth_chain #(
        .SW   (SW),
        .DEPTH(HALF)
    ) u_lower (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (lower_op_reg),
        .v       (lower_v_reg),
        .head_val(lower_head)
    );

    rmth_chain #(
        .SW   (SW),
        .DEPTH(HALF)
    ) u_upper (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (upper_op_reg),
        .v       (upper_v_reg),
        .head_val(upper_head)
    );

    // Chain heads as sample values, and the stored count.
    assign ltop     = ~lower_head;
    assign ltop_ext = {ltop[SW-1], ltop};
    assign utop_ext = {upper_head[SW-1], upper_head};
    assign total    = {1'b0, lc_reg} + {1'b0, uc_reg};

    // Sequencer: capture, decide, apply, report.
    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        lc_next       = lc_reg;
        uc_next       = uc_reg;
        lower_op_next = OP_NONE;
        upper_op_next = OP_NONE;
        lower_v_next  = lower_v_reg;
        upper_v_next  = upper_v_reg;
        dropped_next  = dropped_reg;
        m_valid_next  = m_valid_reg;
        median_next   = median_reg;
        count_next    = count_reg;
        full_next     = full_reg;
        s_ready       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sample_next = s_sample;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                dropped_next = 1'b0;
                priority if (total >= TW'(CAPACITY)) begin
                    dropped_next = 1'b1;
                end else if (lc_reg == '0 || sample_reg < ltop) begin
                    if (lc_reg > uc_reg) begin
                        // Sample displaces the lower head, which moves up.
                        lower_op_next = OP_REPLACE;
                        lower_v_next  = ~sample_reg;
                        upper_op_next = OP_PUSH;
                        upper_v_next  = ltop;
                        uc_next       = uc_reg + 1'b1;
                    end else begin
                        lower_op_next = OP_PUSH;
                        lower_v_next  = ~sample_reg;
                        lc_next       = lc_reg + 1'b1;
                    end
                end else if (uc_reg >= lc_reg) begin
                    if (uc_reg == '0 || sample_reg <= upper_head) begin
                        lower_op_next = OP_PUSH;
                        lower_v_next  = ~sample_reg;
                    end else begin
                        // Sample displaces the upper head, which moves down.
                        upper_op_next = OP_REPLACE;
                        upper_v_next  = sample_reg;
                        lower_op_next = OP_PUSH;
                        lower_v_next  = ~upper_head;
                    end
                    lc_next = lc_reg + 1'b1;
                end else begin
                    upper_op_next = OP_PUSH;
                    upper_v_next  = sample_reg;
                    uc_next       = uc_reg + 1'b1;
                end
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (lc_reg == '0) begin
                        median_next = '0;
                    end else if (total[0] || uc_reg == '0) begin
                        median_next = ltop_ext + ltop_ext;
                    end else begin
                        median_next = ltop_ext + utop_ext;
                    end
                    count_next = COUNT_W'(total);
                    full_next  = dropped_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state resets; payload registers do not.
    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        lower_v_reg <= lower_v_next;
        upper_v_reg <= upper_v_next;
        dropped_reg <= dropped_next;
        median_reg  <= median_next;
        count_reg   <= count_next;
        full_reg    <= full_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lc_reg       <= '0;
            uc_reg       <= '0;
            lower_op_reg <= OP_NONE;
            upper_op_reg <= OP_NONE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lc_reg       <= lc_next;
            uc_reg       <= uc_next;
            lower_op_reg <= lower_op_next;
            upper_op_reg <= upper_op_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_median_times_two = median_reg;
    assign m_sample_count     = count_reg;
    assign m_store_full       = full_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the two-heap running median block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = rmth_pkg::SAMPLE_WIDTH_DEF;
    localparam int CAP      = rmth_pkg::CAPACITY_DEF;
    localparam int CNT_W    = rmth_pkg::COUNT_W;

    // One row of directed stimulus; the result fields count only when typed is set.
    typedef struct packed {
        logic                typed;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W:0]   med;
        logic [CNT_W-1:0]    cnt;
        logic                full;
    } stim_row_t;

    // One result of the block as the checker sees it.
    typedef struct packed {
        logic [SAMPLE_W:0] med;
        logic [CNT_W-1:0]  cnt;
        logic              full;
    } median_result_t;

    localparam int DIRECTED_ROWS = 21;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Extremes right after reset, with results worked out by hand.
        '{1'b1, 32'h7FFF_FFFF, 33'h0_FFFF_FFFE, 9'd1, 1'b0},
        '{1'b1, 32'h8000_0000, 33'h1_FFFF_FFFF, 9'd2, 1'b0},
        '{1'b1, 32'h8000_0000, 33'h1_0000_0000, 9'd3, 1'b0},
        '{1'b1, 32'h7FFF_FFFF, 33'h1_FFFF_FFFF, 9'd4, 1'b0},
        '{1'b1, 32'h0000_0000, 33'h0_0000_0000, 9'd5, 1'b0},
        '{1'b1, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 9'd6, 1'b0},
        '{1'b1, 32'h0000_0000, 33'h0_0000_0000, 9'd7, 1'b0},
        // Ties with both tops, alternating bit patterns, and runs both ways.
        '{1'b0, 32'h0000_0000, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h0000_0001, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'hFFFF_FFFE, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h5555_5555, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'hAAAA_AAAA, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h7FFF_FFFE, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h8000_0001, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h0000_0005, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h0000_0005, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h0000_0005, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h0000_0100, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'hFFFF_FF00, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'h4000_0000, 33'h0, 9'd0, 1'b0},
        '{1'b0, 32'hC000_0000, 33'h0, 9'd0, 1'b0}
    };

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W:0]   m_median_times_two;
    logic [CNT_W-1:0]           m_sample_count;
    logic                       m_store_full;

    // Predictor state: every stored sample, kept in ascending order.
    logic signed [SAMPLE_W-1:0] sorted_samples [CAP];
    int                         held_count = 0;

    median_result_t pending_medians [$];
    median_result_t oldest;
    stim_row_t      cur_row;
    int             error_count    = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    logic [SAMPLE_W-1:0] cluster_base;

    running_median_two_heaps dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample           (s_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_median_times_two (m_median_times_two),
        .m_sample_count     (m_sample_count),
        .m_store_full       (m_store_full)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Insert a sample into the sorted store and report twice the median.
    // The lower half holds ceil(n/2) samples, so its top is the middle one
    // for an odd count and the left of the middle pair for an even count.
    function automatic median_result_t absorb_sample(input logic signed [SAMPLE_W-1:0] v);
        median_result_t             r;
        int                         i;
        logic signed [SAMPLE_W-1:0] lo_top;
        logic signed [SAMPLE_W-1:0] hi_top;
        r.full = 1'b0;
        if (held_count >= CAP) begin
            r.full = 1'b1;
        end else begin
            i = held_count;
            while (i > 0 && sorted_samples[i-1] > v) begin
                sorted_samples[i] = sorted_samples[i-1];
                i--;
            end
            sorted_samples[i] = v;
            held_count++;
        end
        lo_top = sorted_samples[(held_count + 1) / 2 - 1];
        hi_top = (held_count % 2 == 1) ? lo_top : sorted_samples[held_count / 2];
        r.med = {lo_top[SAMPLE_W-1], lo_top} + {hi_top[SAMPLE_W-1], hi_top};
        r.cnt = CNT_W'(held_count);
        return r;
    endfunction

    // Mix of wide random values, small values with many ties, values near
    // the extremes, and a tight cluster.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        int unsigned pick;
        int          d;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return $urandom;
        end else if (pick < 65) begin
            d = $urandom_range(16);
            return SAMPLE_W'(d - 8);
        end else if (pick < 80) begin
            if ($urandom_range(1) == 1)
                return 32'h7FFF_FFFF - $urandom_range(3);
            return 32'h8000_0000 + $urandom_range(3);
        end
        return cluster_base + $urandom_range(63);
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= row.sample;
        cur_row  <= row;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Each accepted request queues the result it must produce.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (cur_row.typed) begin
                pending_medians.push_back({cur_row.med, cur_row.cnt, cur_row.full});
                void'(absorb_sample(s_sample));
            end else begin
                pending_medians.push_back(absorb_sample(s_sample));
            end
        end
    end

    // Each accepted result is checked against the oldest queued one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: result with none pending: median_times_two %0d count %0d",
                         $time, m_median_times_two, m_sample_count);
                error_count++;
            end else begin
                oldest = pending_medians.pop_front();
                if (m_median_times_two !== oldest.med) begin
                    $display("%0t: median_times_two expected %0d, got %0d", $time,
                             $signed(oldest.med), m_median_times_two);
                    error_count++;
                end
                if (m_sample_count !== oldest.cnt) begin
                    $display("%0t: sample_count expected %0d, got %0d", $time,
                             oldest.cnt, m_sample_count);
                    error_count++;
                end
                if (m_store_full !== oldest.full) begin
                    $display("%0t: store_full expected %0b, got %0b", $time,
                             oldest.full, m_store_full);
                    error_count++;
                end
            end
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Stimulus, drain and verdict.
    initial begin
        int k;
        int phase;
        s_valid  = 1'b0;
        s_sample = '0;
        m_ready  = 1'b0;
        cur_row  = '0;
        aresetn  = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            send_request(DIRECTED[k]);
        end

        cluster_base = $urandom;
        for (k = 0; k < 580; k++) begin
            // Rotate through the idling patterns in blocks of forty requests.
            phase = (k / 40) % 4;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            // Once, let the block drain completely before going on.
            if (k == 200) begin
                s_valid <= 1'b0;
                do @(negedge aclk); while (pending_medians.size() != 0);
            end
            send_request('{1'b0, random_sample(), 33'd0, 9'd0, 1'b0});
        end
        s_valid <= 1'b0;

        while (pending_medians.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
